/* design/tpi_pkg.sv */
// Shared constants, types and the tanh lookup table of the tanh perceptron block.
`timescale 1ns / 1ps
package tpi_pkg;

    // Store sizes and field widths
    localparam int MAX_INPUTS  = 8;
    localparam int MAX_NEURONS = 16;
    localparam int TANH_DEPTH  = 256;

    localparam int IIDX_W  = $clog2(MAX_INPUTS);
    localparam int NIDX_W  = $clog2(MAX_NEURONS);
    localparam int WADDR_W = NIDX_W + IIDX_W;
    localparam int WDEPTH  = MAX_NEURONS * MAX_INPUTS;

    localparam int DATA_W    = 32;
    localparam int KIND_W    = 3;
    localparam int NI_CFG_W  = 4;
    localparam int NN_CFG_W  = 5;
    localparam int CFG_W     = 5;
    localparam int CFG_IDX_W = 1;

    localparam int S_TUSER_W = 1 + KIND_W;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 32;

    // Arithmetic widths
    localparam int Q_FRAC    = 16;
    localparam int TANH_FRAC = 19;
    localparam int ROM_W     = 18;
    localparam int ROM_IDX_W = $clog2(TANH_DEPTH);
    localparam int ACC_W     = 52;
    localparam int PROD_W    = 64;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_INPUTS  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_NEURONS = 1'b1;

    // Coefficient kinds; codes 6 and 7 are ignored
    typedef enum logic [KIND_W-1:0] {
        KIND_HBIAS   = 3'd0,
        KIND_IWEIGHT = 3'd1,
        KIND_OWEIGHT = 3'd2,
        KIND_OBIAS   = 3'd3,
        KIND_OFFSET  = 3'd4,
        KIND_SCALE   = 3'd5
    } t_kind;

    // Datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE,
        OP_NORM_MUL,
        OP_NORM_ST,
        OP_TOT_INIT,
        OP_ACC_INIT,
        OP_MAC,
        OP_TANH_IDX,
        OP_TANH_MUL,
        OP_TANH_FIN,
        OP_OUT_MUL,
        OP_OUT_ACC,
        OP_RESULT
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [NIDX_W-1:0] neuron;
        logic [IIDX_W-1:0] input_idx;
    } t_dp_cmd;

    typedef logic signed [ROM_W-1:0] t_rom [0:TANH_DEPTH];

    // Saturate a wide signed value to 32 bits.
    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] hi;
        logic signed [PROD_W-1:0] lo;
        hi = PROD_W'(64'sh7FFF_FFFF);
        lo = -PROD_W'(64'sh8000_0000);
        if (v > hi) begin
            return DATA_W'(hi);
        end else if (v < lo) begin
            return DATA_W'(lo);
        end
        return DATA_W'(v);
    endfunction

    // Unsigned 64-bit quotient by restoring shift and subtract, for table building.
    function automatic longint unsigned udiv64(input longint unsigned num,
                                               input longint unsigned dvs);
        longint unsigned quo;
        longint unsigned rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            if (rem >= dvs) begin
                rem    = rem - dvs;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Table of tanh at -4 + 8k/depth, built at elaboration from a truncated
    // Taylor series of exp in Q32.
    function automatic t_rom build_rom();
        t_rom                rom;
        longint              s;
        longint unsigned     a;
        longint unsigned     y;
        longint unsigned     sum;
        longint unsigned     term;
        longint unsigned     n;
        longint unsigned     one;
        longint unsigned     den;
        longint unsigned     q;
        one = 64'd1 << 32;
        for (int k = 0; k <= TANH_DEPTH; k++) begin
            s    = 8 * k - 4 * TANH_DEPTH;
            a    = (s < 0) ? -s : s;
            y    = 2 * ((a << 16) / TANH_DEPTH);
            sum  = one;
            term = one;
            for (n = 1; n < 80 && term != 0; n++) begin
                term = udiv64((term * y) >> 16, n);
                sum  = sum + term;
            end
            den = sum + one;
            q   = udiv64(((sum - one) << 16) + (den >> 1), den);
            rom[k] = (s < 0) ? ROM_W'(-q) : ROM_W'(q);
        end
        return rom;
    endfunction

    localparam t_rom TANH_ROM = build_rom();

endpackage

/* design/tpi_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module tpi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    // One write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* design/tpi_ctrl.sv */
// Controller state machine that sequences normalisation and network evaluation.
`timescale 1ns / 1ps
module tpi_ctrl (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_accept,
    input  logic                           i_item_cmd,
    input  logic                           i_item_last,
    input  logic [tpi_pkg::NI_CFG_W-1:0]   i_active_inputs,
    input  logic [tpi_pkg::NN_CFG_W-1:0]   i_active_neurons,
    input  logic                           i_out_ready,
    output logic                           o_in_ready,
    output logic                           o_out_valid,
    output tpi_pkg::t_dp_cmd               o_cmd
);
    import tpi_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_NORM_MUL,
        S_NORM_ST,
        S_TOT_INIT,
        S_ACC_INIT,
        S_MAC,
        S_DRAIN1,
        S_DRAIN2,
        S_TANH_IDX,
        S_TANH_MUL,
        S_TANH_FIN,
        S_OUT_MUL,
        S_OUT_ACC,
        S_RESULT
    } t_state;

    t_state              r_state;
    logic                r_last;
    logic                r_out_valid;
    logic [NIDX_W-1:0]   r_nidx;
    logic [IIDX_W-1:0]   r_iidx;

    logic [NI_CFG_W-1:0] ni_c;
    logic [NN_CFG_W-1:0] nn_c;
    logic [IIDX_W-1:0]   last_i;
    logic [NIDX_W-1:0]   last_j;
    logic                slot_free;

    // Out-of-range counts act as the nearest legal count.
    always_comb begin
        if (i_active_inputs == '0) begin
            ni_c = NI_CFG_W'(1);
        end else if (i_active_inputs > NI_CFG_W'(MAX_INPUTS)) begin
            ni_c = NI_CFG_W'(MAX_INPUTS);
        end else begin
            ni_c = i_active_inputs;
        end
        if (i_active_neurons == '0) begin
            nn_c = NN_CFG_W'(1);
        end else if (i_active_neurons > NN_CFG_W'(MAX_NEURONS)) begin
            nn_c = NN_CFG_W'(MAX_NEURONS);
        end else begin
            nn_c = i_active_neurons;
        end
        last_i = IIDX_W'(ni_c - NI_CFG_W'(1));
        last_j = NIDX_W'(nn_c - NN_CFG_W'(1));
    end

    assign slot_free = !r_out_valid || i_out_ready;

    // State, counters and the output valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
            r_nidx      <= '0;
            r_iidx      <= '0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_accept && i_item_cmd) begin
                        r_last  <= i_item_last;
                        r_state <= S_NORM_MUL;
                    end
                end
                S_NORM_MUL: r_state <= S_NORM_ST;
                S_NORM_ST:  r_state <= r_last ? S_TOT_INIT : S_IDLE;
                S_TOT_INIT: begin
                    r_nidx  <= '0;
                    r_state <= S_ACC_INIT;
                end
                S_ACC_INIT: begin
                    r_iidx  <= '0;
                    r_state <= S_MAC;
                end
                S_MAC: begin
                    if (r_iidx == last_i) begin
                        r_state <= S_DRAIN1;
                    end else begin
                        r_iidx <= r_iidx + IIDX_W'(1);
                    end
                end
                S_DRAIN1:   r_state <= S_DRAIN2;
                S_DRAIN2:   r_state <= S_TANH_IDX;
                S_TANH_IDX: r_state <= S_TANH_MUL;
                S_TANH_MUL: r_state <= S_TANH_FIN;
                S_TANH_FIN: r_state <= S_OUT_MUL;
                S_OUT_MUL:  r_state <= S_OUT_ACC;
                S_OUT_ACC: begin
                    if (r_nidx == last_j) begin
                        r_state <= S_RESULT;
                    end else begin
                        r_nidx  <= r_nidx + NIDX_W'(1);
                        r_state <= S_ACC_INIT;
                    end
                end
                S_RESULT: begin
                    if (slot_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Operation decode for the datapath.
    always_comb begin
        o_cmd.neuron    = r_nidx;
        o_cmd.input_idx = r_iidx;
        unique case (r_state)
            S_NORM_MUL: o_cmd.op = OP_NORM_MUL;
            S_NORM_ST:  o_cmd.op = OP_NORM_ST;
            S_TOT_INIT: o_cmd.op = OP_TOT_INIT;
            S_ACC_INIT: o_cmd.op = OP_ACC_INIT;
            S_MAC:      o_cmd.op = OP_MAC;
            S_TANH_IDX: o_cmd.op = OP_TANH_IDX;
            S_TANH_MUL: o_cmd.op = OP_TANH_MUL;
            S_TANH_FIN: o_cmd.op = OP_TANH_FIN;
            S_OUT_MUL:  o_cmd.op = OP_OUT_MUL;
            S_OUT_ACC:  o_cmd.op = OP_OUT_ACC;
            S_RESULT:   o_cmd.op = slot_free ? OP_RESULT : OP_NONE;
            default:    o_cmd.op = OP_NONE;
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

/* design/tpi_dp.sv */
// Datapath: coefficient stores, shared multiplier, accumulators and tanh interpolation.
`timescale 1ns / 1ps
module tpi_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_load,
    input  logic                               i_item_cmd,
    input  logic [tpi_pkg::KIND_W-1:0]         i_coef_kind,
    input  logic [tpi_pkg::NIDX_W-1:0]         i_neuron_index,
    input  logic [tpi_pkg::IIDX_W-1:0]         i_input_index,
    input  logic signed [tpi_pkg::DATA_W-1:0]  i_value,
    input  tpi_pkg::t_dp_cmd                   i_cmd,
    output logic signed [tpi_pkg::DATA_W-1:0]  o_result
);
    import tpi_pkg::*;

    localparam logic signed [ACC_W-1:0]  TLIM  = ACC_W'(4) <<< Q_FRAC;
    localparam logic signed [ROM_W-1:0]  T_ONE = ROM_W'(1) <<< Q_FRAC;
    localparam logic signed [PROD_W-1:0] HALF16 = PROD_W'(1) <<< (Q_FRAC - 1);
    localparam logic signed [PROD_W-1:0] HALF19 = PROD_W'(1) <<< (TANH_FRAC - 1);
    localparam logic signed [PROD_W-1:0] THREE = PROD_W'(3) <<< Q_FRAC;
    localparam int SHIFT_W = TANH_FRAC - ROM_IDX_W;

    // Coefficient stores
    logic signed [DATA_W-1:0] r_hbias   [0:MAX_NEURONS-1];
    logic signed [DATA_W-1:0] r_oweight [0:MAX_NEURONS-1];
    logic signed [DATA_W-1:0] r_offset  [0:MAX_INPUTS-1];
    logic signed [DATA_W-1:0] r_scale   [0:MAX_INPUTS-1];
    logic signed [DATA_W-1:0] r_obias;
    logic [WDEPTH-1:0]        r_wvalid;
    logic signed [DATA_W-1:0] r_xnorm   [0:MAX_INPUTS-1];

    // Latched sample item
    logic [IIDX_W-1:0]        r_iidx;
    logic signed [DATA_W-1:0] r_value;

    // Multiply-accumulate pipeline
    logic                     r_v1;
    logic                     r_v2;
    logic                     r_wv1;
    logic [IIDX_W-1:0]        r_s1_idx;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [PROD_W-1:0] r_total;

    // Tanh stage
    logic signed [ROM_W-1:0]  r_lo;
    logic signed [ROM_W:0]    r_diff;
    logic [TANH_FRAC-1:0]     r_frac;
    logic                     r_tpos;
    logic                     r_tneg;
    logic signed [ROM_W-1:0]  r_th;
    logic signed [DATA_W-1:0] r_result;

    logic                     wr_coef;
    logic                     wr_weight;
    logic [WADDR_W-1:0]       waddr;
    logic [WADDR_W-1:0]       raddr;
    logic [DATA_W-1:0]        ram_q;
    logic signed [DATA_W-1:0] w_eff;
    logic signed [DATA_W:0]   diff33;
    logic signed [DATA_W-1:0] dsat;
    logic signed [DATA_W-1:0] m_a;
    logic signed [DATA_W-1:0] m_b;
    logic signed [PROD_W-1:0] rnd16;
    logic signed [PROD_W-1:0] rnd19;
    logic signed [PROD_W-1:0] rnd_tot;
    logic signed [ACC_W-1:0]  t_off;
    logic [ROM_IDX_W-1:0]     tidx;
    logic signed [ROM_W-1:0]  rom_lo;
    logic signed [ROM_W-1:0]  rom_hi;

    assign wr_coef   = i_load && !i_item_cmd;
    assign wr_weight = wr_coef && (t_kind'(i_coef_kind) == KIND_IWEIGHT);
    assign waddr     = {i_neuron_index, i_input_index};
    assign raddr     = {i_cmd.neuron, i_cmd.input_idx};

    tpi_ram #(
        .WIDTH (DATA_W),
        .DEPTH (WDEPTH)
    ) u_wram (
        .i_clk   (i_clk),
        .i_we    (wr_weight),
        .i_waddr (waddr),
        .i_wdata (i_value),
        .i_raddr (raddr),
        .o_rdata (ram_q)
    );

    // Arithmetic that feeds the registers
    always_comb begin
        w_eff   = r_wv1 ? DATA_W'(ram_q) : '0;
        diff33  = (DATA_W + 1)'(r_value) - (DATA_W + 1)'(r_offset[r_iidx]);
        dsat    = sat32(PROD_W'(diff33));
        rnd16   = (r_prod + HALF16) >>> Q_FRAC;
        rnd19   = (r_prod + HALF19) >>> TANH_FRAC;
        rnd_tot = (r_total + HALF16) >>> Q_FRAC;
        t_off   = r_acc + TLIM;
        tidx    = t_off[TANH_FRAC-1 -: ROM_IDX_W];
        rom_lo  = TANH_ROM[tidx];
        rom_hi  = TANH_ROM[(ROM_IDX_W + 1)'(tidx) + (ROM_IDX_W + 1)'(1)];
        if (r_v1) begin
            m_a = w_eff;
            m_b = r_xnorm[r_s1_idx];
        end else begin
            unique case (i_cmd.op)
                OP_NORM_MUL: begin
                    m_a = dsat;
                    m_b = r_scale[r_iidx];
                end
                OP_TANH_MUL: begin
                    m_a = DATA_W'(r_diff);
                    m_b = DATA_W'(r_frac);
                end
                OP_OUT_MUL: begin
                    m_a = DATA_W'(r_th);
                    m_b = r_oweight[i_cmd.neuron];
                end
                default: begin
                    m_a = '0;
                    m_b = '0;
                end
            endcase
        end
    end

    // Coefficient stores and pipeline control, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int n = 0; n < MAX_NEURONS; n++) begin
                r_hbias[n]   <= '0;
                r_oweight[n] <= '0;
            end
            for (int m = 0; m < MAX_INPUTS; m++) begin
                r_offset[m] <= '0;
                r_scale[m]  <= '0;
            end
            r_obias  <= '0;
            r_wvalid <= '0;
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
        end else begin
            r_v1 <= (i_cmd.op == OP_MAC);
            r_v2 <= r_v1;
            if (wr_coef) begin
                unique case (t_kind'(i_coef_kind))
                    KIND_HBIAS:   r_hbias[i_neuron_index]   <= i_value;
                    KIND_IWEIGHT: r_wvalid[waddr]           <= 1'b1;
                    KIND_OWEIGHT: r_oweight[i_neuron_index] <= i_value;
                    KIND_OBIAS:   r_obias                   <= i_value;
                    KIND_OFFSET:  r_offset[i_input_index]   <= i_value;
                    KIND_SCALE:   r_scale[i_input_index]    <= i_value;
                    default: ;
                endcase
            end
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_prod   <= m_a * m_b;
        r_wv1    <= r_wvalid[raddr];
        r_s1_idx <= i_cmd.input_idx;
        if (i_load && i_item_cmd) begin
            r_iidx  <= i_input_index;
            r_value <= i_value;
        end
        if (r_v2) begin
            r_acc <= r_acc + ACC_W'(rnd16);
        end
        unique case (i_cmd.op)
            OP_NORM_ST:  r_xnorm[r_iidx] <= sat32(rnd16 - THREE);
            OP_TOT_INIT: r_total <= PROD_W'(r_obias) <<< Q_FRAC;
            OP_ACC_INIT: r_acc <= ACC_W'(r_hbias[i_cmd.neuron]);
            OP_TANH_IDX: begin
                r_tneg <= (r_acc < -TLIM);
                r_tpos <= (r_acc >= TLIM);
                r_lo   <= rom_lo;
                r_diff <= (ROM_W + 1)'(rom_hi) - (ROM_W + 1)'(rom_lo);
                r_frac <= {t_off[SHIFT_W-1:0], ROM_IDX_W'(0)};
            end
            OP_TANH_FIN: begin
                if (r_tpos) begin
                    r_th <= T_ONE;
                end else if (r_tneg) begin
                    r_th <= -T_ONE;
                end else begin
                    r_th <= r_lo + ROM_W'(rnd19);
                end
            end
            OP_OUT_ACC:  r_total <= r_total + r_prod;
            OP_RESULT:   r_result <= sat32(rnd_tot);
            default: ;
        endcase
    end

    assign o_result = r_result;

endmodule

/* design/tanh_perceptron_inference.sv */
// Top level of the tanh perceptron inference block.
// A coefficient item is stored on acceptance and does not stall the input; a
// sample item without last holds the input while it is normalised; one with
// last also runs the network (N neurons, I inputs). One shared 32x32 multiplier,
// fed one weight per cycle in the MAC state, forms every product. Reset is
// synchronous, active low; the coefficient stores clear at once, no clearing pass.
`timescale 1ns / 1ps
module tanh_perceptron_inference (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // neuron_index [3:0], input_index [6:4], value [38:7], zero [39]
    input  logic [tpi_pkg::S_TDATA_W-1:0]       i_s_axis_tdata,
    // cmd [0], coef_kind [3:1]
    input  logic [tpi_pkg::S_TUSER_W-1:0]       i_s_axis_tuser,
    input  logic                                i_s_axis_tlast,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // net_output [31:0]
    output logic [tpi_pkg::M_TDATA_W-1:0]       o_m_axis_tdata,
    input  logic                                i_cfg_we,
    input  logic [tpi_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [tpi_pkg::CFG_W-1:0]           i_cfg_data
);
    import tpi_pkg::*;

    logic [NI_CFG_W-1:0]      r_active_inputs;
    logic [NN_CFG_W-1:0]      r_active_neurons;
    logic                     accept;
    t_dp_cmd                  dp_cmd;
    logic signed [DATA_W-1:0] result;

    assign accept = i_s_axis_tvalid && o_s_axis_tready;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_inputs  <= NI_CFG_W'(1);
            r_active_neurons <= NN_CFG_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ACTIVE_INPUTS:  r_active_inputs  <= i_cfg_data[NI_CFG_W-1:0];
                CFG_ACTIVE_NEURONS: r_active_neurons <= i_cfg_data[NN_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    tpi_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (accept),
        .i_item_cmd       (i_s_axis_tuser[0]),
        .i_item_last      (i_s_axis_tlast),
        .i_active_inputs  (r_active_inputs),
        .i_active_neurons (r_active_neurons),
        .i_out_ready      (i_m_axis_tready),
        .o_in_ready       (o_s_axis_tready),
        .o_out_valid      (o_m_axis_tvalid),
        .o_cmd            (dp_cmd)
    );

    tpi_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (accept),
        .i_item_cmd     (i_s_axis_tuser[0]),
        .i_coef_kind    (i_s_axis_tuser[KIND_W:1]),
        .i_neuron_index (i_s_axis_tdata[NIDX_W-1:0]),
        .i_input_index  (i_s_axis_tdata[NIDX_W+IIDX_W-1:NIDX_W]),
        .i_value        (i_s_axis_tdata[NIDX_W+IIDX_W+DATA_W-1:NIDX_W+IIDX_W]),
        .i_cmd          (dp_cmd),
        .o_result       (result)
    );

    assign o_m_axis_tdata = result;

    // After reset the block is ready and holds no result.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (o_s_axis_tready && !o_m_axis_tvalid))
        else $error("block not idle after reset");

    // A coefficient item completes in its own cycle.
    a_coef_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !i_s_axis_tuser[0]) |=> o_s_axis_tready)
        else $error("coefficient item stalled the input");

    // A sample item always occupies the sequencer.
    a_sample_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_s_axis_tuser[0]) |=> !o_s_axis_tready)
        else $error("sample item did not start normalisation");

endmodule

/* dv/tanh_perceptron_inference_tb.sv */
// Self-checking testbench for the tanh perceptron inference block.
`timescale 1ns / 1ps
module tanh_perceptron_inference_tb;
    import tpi_pkg::*;

    // Item commands as carried in tuser bit 0
    localparam bit CMD_COEF   = 1'b0;
    localparam bit CMD_SAMPLE = 1'b1;
    localparam int Q_UNIT     = 65536;
    localparam int HOLD_LEN   = 3000;

    typedef struct {
        bit       cmd;
        bit [2:0] kind;
        bit [3:0] neuron;
        bit [2:0] elem;
        int       value;
        bit       last;
    } t_req;

    // Network predictor: its own copy of the coefficient stores, the settings
    // and the tanh table, and the queue of outputs still owed by the block.
    class net_scoreboard;
        int     in_wt [MAX_NEURONS*MAX_INPUTS];
        int     hid_bias [MAX_NEURONS];
        int     out_wt [MAX_NEURONS];
        int     out_bias;
        int     offs [MAX_INPUTS];
        int     scl [MAX_INPUTS];
        int     norm [MAX_INPUTS];
        bit [3:0] n_in;
        bit [4:0] n_neu;
        longint tanh_tab [TANH_DEPTH+1];
        int     owed_q [$];

        function new();
            longint s;
            longint unsigned a, y, e, term, one, den, q;
            one = 64'd1 << 32;
            for (int k = 0; k <= TANH_DEPTH; k++) begin
                s = 8 * k - 4 * TANH_DEPTH;
                a = (s < 0) ? -s : s;
                y = 2 * ((a << 16) / TANH_DEPTH);
                e = one;
                term = one;
                for (int n = 1; n < 80 && term != 0; n++) begin
                    term = ((term * y) >> 16) / n;
                    e += term;
                end
                den = e + one;
                q = (((e - one) << 16) + den / 2) / den;
                tanh_tab[k] = (s < 0) ? -longint'(q) : longint'(q);
            end
            foreach (in_wt[i]) in_wt[i] = 0;
            foreach (hid_bias[i]) begin
                hid_bias[i] = 0;
                out_wt[i] = 0;
            end
            foreach (offs[i]) begin
                offs[i] = 0;
                scl[i] = 0;
                norm[i] = 0;
            end
            out_bias = 0;
            n_in = 1;
            n_neu = 1;
        endfunction

        function longint clip32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        // Arithmetic shift with round to nearest, ties towards plus infinity.
        function longint shift_round(longint v, int s);
            return (v + (64'sd1 <<< (s - 1))) >>> s;
        endfunction

        function longint tanh_q(longint t);
            longint lim, pos, idx, frac, lo, hi;
            lim = 4 * Q_UNIT;
            if (t < -lim) return -Q_UNIT;
            if (t >= lim) return Q_UNIT;
            pos = (t + lim) * TANH_DEPTH;
            idx = pos >>> TANH_FRAC;
            frac = pos & ((64'sd1 <<< TANH_FRAC) - 1);
            if (idx >= TANH_DEPTH) idx = TANH_DEPTH - 1;
            lo = tanh_tab[idx];
            hi = tanh_tab[idx+1];
            return lo + shift_round((hi - lo) * frac, TANH_FRAC);
        endfunction

        function void set_counts(bit [3:0] ni, bit [4:0] nn);
            n_in = ni;
            n_neu = nn;
        endfunction

        function int network_output();
            int     ni, nn;
            longint total, acc;
            ni = (n_in == 0) ? 1 : (n_in > MAX_INPUTS) ? MAX_INPUTS : n_in;
            nn = (n_neu == 0) ? 1 : (n_neu > MAX_NEURONS) ? MAX_NEURONS : n_neu;
            total = longint'(out_bias) * Q_UNIT;
            for (int j = 0; j < nn; j++) begin
                acc = hid_bias[j];
                for (int i = 0; i < ni; i++)
                    acc += shift_round(longint'(in_wt[j*MAX_INPUTS+i]) * norm[i], 16);
                total += tanh_q(acc) * out_wt[j];
            end
            return int'(clip32(shift_round(total, 16)));
        endfunction

        // Applies one accepted item and queues the output it causes, if any.
        function void note_item(t_req r);
            longint d, p;
            if (r.cmd == CMD_COEF) begin
                case (r.kind)
                    KIND_HBIAS:   hid_bias[r.neuron] = r.value;
                    KIND_IWEIGHT: in_wt[r.neuron*MAX_INPUTS + r.elem] = r.value;
                    KIND_OWEIGHT: out_wt[r.neuron] = r.value;
                    KIND_OBIAS:   out_bias = r.value;
                    KIND_OFFSET:  offs[r.elem] = r.value;
                    KIND_SCALE:   scl[r.elem] = r.value;
                    default: ;
                endcase
                return;
            end
            d = clip32(longint'(r.value) - offs[r.elem]);
            p = shift_round(d * scl[r.elem], 16);
            norm[r.elem] = int'(clip32(p - 3 * Q_UNIT));
            if (r.last) owed_q.push_back(network_output());
        endfunction

        // Compares one accepted output with the oldest owed one.
        function bit check_output(int got, output string why);
            int want;
            if (owed_q.size() == 0) begin
                why = $sformatf("unexpected output %h", got);
                return 0;
            end
            want = owed_q.pop_front();
            if (got != want) begin
                why = $sformatf("net_output %h, predicted %h", got, want);
                return 0;
            end
            return 1;
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_valid;
    logic                 s_ready;
    logic [S_TDATA_W-1:0] s_data;
    logic [S_TUSER_W-1:0] s_user;
    logic                 s_last;
    logic                 m_valid;
    logic                 m_ready;
    logic [M_TDATA_W-1:0] m_data;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    net_scoreboard sb;
    int  errors;
    int  snd_idle_pct;
    int  rcv_stall_pct;
    bit  hold_req;
    int  eff_inputs;

    tanh_perceptron_inference dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .i_s_axis_tlast  (s_last),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    task automatic report_mismatch(string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        errors++;
    endtask

    // Sends one item, idling first at random, and waits for its acceptance.
    task automatic send_item(t_req r);
        bit took;
        if ($urandom_range(99) < snd_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= {1'b0, r.value, r.elem, r.neuron};
        s_user  <= {r.kind, r.cmd};
        s_last  <= r.last;
        do begin
            @(negedge i_clk);
            took = s_ready;
            @(posedge i_clk);
        end while (!took);
        sb.note_item(r);
    endtask

    task automatic send_coef(bit [2:0] kind, bit [3:0] n, bit [2:0] e, int v);
        t_req r;
        r = '{CMD_COEF, kind, n, e, v, 1'b0};
        send_item(r);
    endtask

    task automatic send_sample(bit [2:0] e, int v, bit last);
        t_req r;
        r = '{CMD_SAMPLE, 3'($urandom), 4'($urandom), e, v, last};
        send_item(r);
    endtask

    // Writes both settings; the block must be idle.
    task automatic write_counts(bit [4:0] ni, bit [4:0] nn);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_ACTIVE_INPUTS;
        cfg_data  <= ni;
        @(posedge i_clk);
        cfg_index <= CFG_ACTIVE_NEURONS;
        cfg_data  <= nn;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        sb.set_counts(ni[3:0], nn);
        eff_inputs = (ni[3:0] == 0) ? 1 : (ni[3:0] > MAX_INPUTS) ? MAX_INPUTS : ni[3:0];
    endtask

    // Stops sending and waits until every owed output has come back.
    task automatic settle();
        int guard;
        guard = 0;
        s_valid <= 1'b0;
        while (sb.owed_q.size() > 0 && guard < 50000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (16) @(posedge i_clk);
    endtask

    function automatic int coef_value(bit [2:0] kind);
        if ($urandom_range(99) < 10) return int'($urandom);
        case (kind)
            KIND_SCALE:  return int'($urandom_range(0, 98304));
            KIND_OFFSET: return int'($urandom_range(0, 524288)) - 262144;
            default:     return int'($urandom_range(0, 262144)) - 131072;
        endcase
    endfunction

    function automatic int sample_value();
        if ($urandom_range(99) < 10) return int'($urandom);
        return int'($urandom_range(0, 1048576)) - 524288;
    endfunction

    // Mostly whole samples with random content, plus coefficient bursts
    // and stray elements.
    task automatic run_random(int n_items);
        int       cnt, pick;
        bit [2:0] kind;
        cnt = 0;
        while (cnt < n_items) begin
            pick = $urandom_range(99);
            if (pick < 30) begin
                repeat ($urandom_range(1, 6)) begin
                    kind = ($urandom_range(99) < 5) ? 3'(6 + $urandom_range(1))
                                                    : 3'($urandom_range(5));
                    send_coef(kind, 4'($urandom), 3'($urandom), coef_value(kind));
                    cnt++;
                end
            end else if (pick < 88) begin
                for (int i = 0; i < eff_inputs; i++) begin
                    send_sample(3'(i), sample_value(), i == eff_inputs - 1);
                    cnt++;
                end
            end else begin
                send_sample(3'($urandom), sample_value(), $urandom_range(1));
                cnt++;
            end
        end
    endtask

    // Receiver: random stalls, plus one long hold-off on request.
    initial begin
        int hold_left;
        hold_left = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else if (hold_req) begin
                hold_req = 1'b0;
                hold_left = HOLD_LEN;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= rcv_stall_pct);
            end
        end
    end

    // Output monitor: values are stable from the falling edge to the accepting edge.
    always @(negedge i_clk) begin
        string why;
        if (i_rst_n && m_valid && m_ready) begin
            if (!sb.check_output(int'(m_data), why)) report_mismatch(why);
        end
    end

    initial begin
        #15_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        errors = 0;
        snd_idle_pct = 0;
        rcv_stall_pct = 0;
        hold_req = 1'b0;
        eff_inputs = 1;
        sb = new();
        i_rst_n   <= 1'b0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        s_user    <= '0;
        s_last    <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part with the reset settings: every element gets a value
        // first, then field extremes, every kind and saturation of the output.
        for (int i = 0; i < MAX_INPUTS; i++) send_sample(3'(i), 0, 1'b0);
        send_sample(3'd0, 0, 1'b1);
        send_coef(KIND_HBIAS, 4'd0, 3'd7, 32'sh7FFF_FFFF);
        send_coef(KIND_IWEIGHT, 4'd15, 3'd7, 32'sh8000_0000);
        send_coef(KIND_IWEIGHT, 4'd0, 3'd0, Q_UNIT);
        send_coef(KIND_OWEIGHT, 4'd0, 3'd0, 32'sh7FFF_FFFF);
        send_coef(KIND_OBIAS, 4'd15, 3'd7, 32'sh7FFF_FFFF);
        send_coef(KIND_OFFSET, 4'd0, 3'd0, 32'sh8000_0000);
        send_coef(KIND_SCALE, 4'd0, 3'd0, Q_UNIT);
        send_coef(3'd6, 4'd0, 3'd0, 32'sh1234_5678);
        send_coef(3'd7, 4'd15, 3'd7, -1);
        send_sample(3'd0, 32'sh7FFF_FFFF, 1'b1);
        send_coef(KIND_OBIAS, 4'd0, 3'd0, 32'sh8000_0000);
        send_coef(KIND_OWEIGHT, 4'd0, 3'd0, 32'sh8000_0000);
        send_sample(3'd0, 32'sh8000_0000, 1'b1);
        send_coef(KIND_HBIAS, 4'd0, 3'd0, -4 * Q_UNIT);
        send_coef(KIND_OBIAS, 4'd0, 3'd0, 0);
        send_coef(KIND_OWEIGHT, 4'd0, 3'd0, Q_UNIT);
        send_coef(KIND_SCALE, 4'd0, 3'd0, 0);
        send_sample(3'd0, 0, 1'b1);
        send_sample(3'd7, 32'sh7FFF_FFFF, 1'b1);
        settle();

        // Largest settings, no idling.
        write_counts(5'd8, 5'd16);
        run_random(220);
        settle();

        // Zero counts act as one; sender idles often.
        write_counts(5'd0, 5'd0);
        snd_idle_pct = 66;
        run_random(220);
        settle();

        // Counts beyond the stores; receiver stalls, with one long hold-off.
        write_counts(5'd15, 5'd31);
        snd_idle_pct = 0;
        rcv_stall_pct = 66;
        hold_req = 1'b1;
        run_random(220);
        settle();

        // Random settings, both sides idle.
        write_counts(5'($urandom_range(1, 8)), 5'($urandom_range(1, 16)));
        snd_idle_pct = 38;
        rcv_stall_pct = 38;
        run_random(220);
        settle();
        repeat (300) @(posedge i_clk);

        if (sb.owed_q.size() > 0)
            report_mismatch($sformatf("%0d outputs never came", sb.owed_q.size()));
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

/* filelist.f */
design/tpi_pkg.sv
design/tpi_ram.sv
design/tpi_ctrl.sv
design/tpi_dp.sv
design/tanh_perceptron_inference.sv
dv/tanh_perceptron_inference_tb.sv
